@@ rtl/sbsth_pkg.sv @@
`default_nettype none

package sbsth_pkg;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TOKEN_W   = 20;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TOKEN_W-1:0] TOKEN_MOD = 20'd1000000;

  // floor(h / 1e6) == (h * RECIP_MAGIC) >> RECIP_SHIFT for every 32-bit h
  localparam logic [HASH_W-1:0] RECIP_MAGIC = 32'h431B_DE83;
  localparam int unsigned       RECIP_SHIFT = 50;
  localparam int unsigned       PROD_W      = 2 * HASH_W;
  localparam int unsigned       QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int unsigned       QM_W        = QUOT_W + TOKEN_W;

  typedef logic [HASH_W-1:0] hash_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED = 1'b0,
    CFG_MIX  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic  valid;
    hash_t acc;
  } fin_req_t;

  function automatic hash_t mix_byte(hash_t acc, logic [BYTE_W-1:0] b);
    hash_t t;
    t = acc + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic hash_t fin_step1(hash_t acc);
    hash_t t;
    t = acc + (acc << 3);
    t = t ^ (t >> 11);
    return t;
  endfunction

  function automatic hash_t fin_step2(hash_t acc);
    return acc + (acc << 15);
  endfunction

endpackage

`default_nettype wire

@@ rtl/seeded_byte_stream_token_hash.sv @@
// Throughput: one byte per cycle while in_stall is low; the accumulator recurrence closes through one register.
// Finalize and modulo reduction run in a 5-register pipeline behind it.
// Reset (rst_n low, synchronous): keys and accumulator clear, next byte starts a message,
// all pipeline stages empty.
`default_nettype none

module seeded_byte_stream_token_hash
  import sbsth_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [HASH_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  input  wire logic                 in_last_byte,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [TOKEN_W-1:0]   out_token_value,
  output      logic [HASH_W-1:0]    out_token_masked
);

  hash_t    seed_key_r, seed_key_nxt;
  hash_t    mix_key_r, mix_key_nxt;
  fin_req_t fin_req;
  logic     fin_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    seed_key_nxt = seed_key_r;
    mix_key_nxt  = mix_key_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEED: seed_key_nxt = cfg_wdata;
        CFG_MIX:  mix_key_nxt  = cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_key_r <= '0;
      mix_key_r  <= '0;
    end else begin
      seed_key_r <= seed_key_nxt;
      mix_key_r  <= mix_key_nxt;
    end
  end

  sbsth_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .seed_key     (seed_key_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .fin_ready    (fin_ready),
    .fin_req      (fin_req)
  );

  sbsth_fin u_fin (
    .clk              (clk),
    .rst_n            (rst_n),
    .seed_key         (seed_key_r),
    .mix_key          (mix_key_r),
    .fin_req          (fin_req),
    .fin_ready        (fin_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_value  (out_token_value),
    .out_token_masked (out_token_masked)
  );

endmodule

`default_nettype wire

@@ rtl/sbsth_mix.sv @@
`default_nettype none

module sbsth_mix
  import sbsth_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hash_t             seed_key,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              fin_ready,
  output      fin_req_t          fin_req
);

  hash_t    acc_r, acc_nxt;
  logic     start_r, start_nxt;
  fin_req_t req_r, req_nxt;
  hash_t    mixed;
  logic     in_fire;

  assign in_stall = req_r.valid && !fin_ready;
  assign in_fire  = in_valid && !in_stall;
  assign fin_req  = req_r;

  always_comb begin
    mixed     = mix_byte(start_r ? seed_key : acc_r, in_data_byte);
    acc_nxt   = acc_r;
    start_nxt = start_r;
    req_nxt   = req_r;
    if (fin_ready) begin
      req_nxt.valid = 1'b0;
    end
    if (in_fire) begin
      acc_nxt   = mixed;
      start_nxt = in_last_byte;
      if (in_last_byte) begin
        req_nxt.valid = 1'b1;
        req_nxt.acc   = mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      start_r     <= 1'b1;
      req_r.valid <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      start_r     <= start_nxt;
      req_r.valid <= req_nxt.valid;
    end
    req_r.acc <= req_nxt.acc;
  end

endmodule

`default_nettype wire

@@ rtl/sbsth_fin.sv @@
`default_nettype none

module sbsth_fin
  import sbsth_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hash_t              seed_key,
  input  wire hash_t              mix_key,
  input  wire fin_req_t           fin_req,
  output      logic               fin_ready,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [TOKEN_W-1:0] out_token_value,
  output      logic [HASH_W-1:0]  out_token_masked
);

  // stage valids: a = finalize part 1, b = finalize part 2, c = product, d = quotient times modulus, o = remainder
  logic a_v_r, b_v_r, c_v_r, d_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  hash_t              t_a_r;
  hash_t              h_b_r;
  hash_t              h_c_r;
  logic [PROD_W-1:0]  prod_c_r;
  logic [PROD_W-1:0]  prod_nxt;
  hash_t              h_d_r;
  hash_t              qm_d_r;
  logic [QUOT_W-1:0]  quot;
  logic [QM_W-1:0]    qm_full;
  hash_t              rem;
  logic [TOKEN_W-1:0] token_r;
  hash_t              masked_r;

  assign rdy_o     = !o_v_r || !out_stall;
  assign rdy_d     = !d_v_r || rdy_o;
  assign rdy_c     = !c_v_r || rdy_d;
  assign rdy_b     = !b_v_r || rdy_c;
  assign rdy_a     = !a_v_r || rdy_b;
  assign fin_ready = rdy_a;

  assign prod_nxt = {{HASH_W{1'b0}}, h_b_r} * {{HASH_W{1'b0}}, RECIP_MAGIC};
  assign quot     = prod_c_r[PROD_W-1 -: QUOT_W];
  assign qm_full  = {{TOKEN_W{1'b0}}, quot} * {{QUOT_W{1'b0}}, TOKEN_MOD};
  assign rem      = h_d_r - qm_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v_r <= fin_req.valid;
      end
      if (rdy_b) begin
        b_v_r <= a_v_r;
      end
      if (rdy_c) begin
        c_v_r <= b_v_r;
      end
      if (rdy_d) begin
        d_v_r <= c_v_r;
      end
      if (rdy_o) begin
        o_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      t_a_r <= fin_step1(fin_req.acc);
    end
    if (rdy_b) begin
      h_b_r <= fin_step2(t_a_r) ^ mix_key;
    end
    if (rdy_c) begin
      prod_c_r <= prod_nxt;
      h_c_r    <= h_b_r;
    end
    if (rdy_d) begin
      qm_d_r <= qm_full[HASH_W-1:0];
      h_d_r  <= h_c_r;
    end
    if (rdy_o) begin
      token_r  <= rem[TOKEN_W-1:0];
      masked_r <= {{(HASH_W-TOKEN_W){1'b0}}, rem[TOKEN_W-1:0]} ^ seed_key;
    end
  end

  assign out_valid        = o_v_r;
  assign out_token_value  = token_r;
  assign out_token_masked = masked_r;

endmodule

`default_nettype wire

@@ rtl/sbsth_chk.sv @@
`default_nettype none

module sbsth_chk
  import sbsth_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [TOKEN_W-1:0]   out_token_value,
  input wire logic [HASH_W-1:0]    out_token_masked
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_value)
      && $stable(out_token_masked))
    else $error("stalled result changed");

  a_token_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_value < TOKEN_MOD)
    else $error("token out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind seeded_byte_stream_token_hash sbsth_chk u_sbsth_chk (.*);

`default_nettype wire

@@ sim/seeded_byte_stream_token_hash_tb.sv @@
`timescale 1ns / 1ps

module seeded_byte_stream_token_hash_tb;
  import sbsth_pkg::*;

  localparam int    CYCLE_LIMIT            = 200000;
  localparam int    DRAIN_CYCLES           = 8;
  localparam int    HOLD_CYCLES            = 300;
  localparam int    RANDOM_BYTES_PER_PHASE = 80;
  localparam int    RANDOM_PHASES          = 5;
  localparam hash_t TOKEN_RANGE            = 32'd1000000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [TOKEN_W-1:0] value;
    hash_t              masked;
  } token_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index     = CFG_SEED;
  hash_t              cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_byte  = '0;
  logic               in_last_byte  = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [TOKEN_W-1:0] out_token_value;
  hash_t              out_token_masked;

  hash_t    key_seed      = '0;
  hash_t    key_mix       = '0;
  hash_t    hash_state    = '0;
  bit       at_msg_start  = 1'b1;
  token_t   expected_tokens[$];

  int       mismatches    = 0;
  int       bytes_sent    = 0;
  int       cycle_count   = 0;
  rx_mode_t rx_mode       = RX_OPEN;
  int       rx_phase      = 0;
  int       hold_requests = 0;
  int       hold_grants   = 0;
  int       hold_left     = 0;
  bit       gaps_on       = 1'b1;
  int       burst_left    = 0;

  always #4 clk = ~clk;

  seeded_byte_stream_token_hash uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_value  (out_token_value),
    .out_token_masked (out_token_masked)
  );

  function automatic hash_t oaat_absorb(hash_t acc, logic [BYTE_W-1:0] b);
    hash_t t;
    t = acc + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic hash_t oaat_avalanche(hash_t acc);
    hash_t t;
    t = acc + (acc << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

  function automatic void predict_token(logic [BYTE_W-1:0] b, logic last);
    hash_t  acc;
    hash_t  h;
    token_t tok;
    acc = at_msg_start ? key_seed : hash_state;
    acc = oaat_absorb(acc, b);
    hash_state = acc;
    at_msg_start = last;
    if (last) begin
      h = (oaat_avalanche(acc) ^ key_mix) % TOKEN_RANGE;
      tok.value = h[TOKEN_W-1:0];
      tok.masked = {{(HASH_W-TOKEN_W){1'b0}}, tok.value} ^ key_seed;
      expected_tokens.insert(expected_tokens.size(), tok);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return BYTE_W'($urandom);
  endfunction

  function automatic hash_t pick_key();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic int msg_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 32);
    return $urandom_range(33, 64);
  endfunction

  task automatic write_reg(cfg_idx_t idx, hash_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SEED: key_seed = value;
      CFG_MIX:  key_mix = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_token(b, last);
    bytes_sent++;
  endtask

  task automatic pace_input();
    int gap;
    if (!gaps_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
      pace_input();
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // zero bytes hash like any other and do not end a message
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_idle();
  endtask

  task automatic test_key_extremes();
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_MIX, 32'hFFFF_FFFF);
    send_byte(8'h61, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
    write_reg(CFG_SEED, 32'h0000_0000);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_MIX, 32'h0000_0000);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_seed_mid_message();
    write_reg(CFG_SEED, 32'hA5A5_A5A5);
    write_reg(CFG_MIX, 32'h0F0F_1234);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    wait_idle();
    // accumulator keeps the old seed, the masked half takes the new one
    write_reg(CFG_SEED, 32'h5A5A_5A5A);
    send_byte(8'h40, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_streams();
    int start;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      write_reg(CFG_SEED, pick_key());
      write_reg(CFG_MIX, pick_key());
      case (phase % 3)
        0: rx_mode = RX_RANDOM;
        1: rx_mode = RX_PATTERN;
        default: rx_mode = RX_OPEN;
      endcase
      gaps_on = (phase != 2);
      burst_left = 0;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES_PER_PHASE) send_message(msg_length());
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    rx_mode = RX_OPEN;
    gaps_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 40; i++) send_message($urandom_range(1, 3));
    wait_drain();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 10; i++) send_message($urandom_range(1, 4));
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_grants != hold_requests) begin
      hold_grants <= hold_grants + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
        RX_PATTERN: out_stall <= ((rx_phase % 11) < 4);
        default:    out_stall <= 1'b0;
      endcase
    end
    rx_phase <= rx_phase + 1;
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token transfer: token_value %0d token_masked %h",
               out_token_value, out_token_masked);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_token_value !== want.value) begin
          $error("token_value expected %0d actual %0d", want.value, out_token_value);
          mismatches++;
        end
        if (out_token_masked !== want.masked) begin
          $error("token_masked expected %h actual %h", want.masked, out_token_masked);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_key_extremes();
    test_seed_mid_message();
    test_random_streams();
    test_backpressure();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
